### hw/rtl/rtsp_request_header_parser_top_defines.svh
// Assertion macros for the request header parser.
`ifndef RTSP_REQUEST_HEADER_PARSER_TOP_DEFINES_SVH
`define RTSP_REQUEST_HEADER_PARSER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define RHP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RHP_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RHP_ASSERT(label, clk, rst_n, prop, msg)
`define RHP_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### hw/rtl/rhp_pkg.sv
// Shared types and constants of the request header parser.
package rhp_pkg;
	localparam int LINE_LIMIT = 1023;
	localparam int LC_W = $clog2(LINE_LIMIT + 1);
	localparam logic [3:0] ST_OK = 4'd0;
	localparam logic [3:0] ST_BAD_METHOD = 4'd1;
	localparam logic [3:0] ST_METHOD_CHAR = 4'd2;
	localparam logic [3:0] ST_URL_CHAR = 4'd3;
	localparam logic [3:0] ST_PROTO = 4'd4;
	localparam logic [3:0] ST_HDR_CHAR = 4'd5;
	localparam logic [3:0] ST_NO_SPACE = 4'd6;
	localparam logic [3:0] ST_CSEQ = 4'd7;
	localparam logic [3:0] ST_TRANSPORT = 4'd8;
	localparam logic [3:0] ST_PORT = 4'd9;
	localparam logic [3:0] ST_LINE_LONG = 4'd10;

	typedef struct packed {
		logic [3:0] status;
		logic [2:0] method;
		logic [30:0] sequence_number;
		logic [15:0] rtp_port_low;
		logic [15:0] rtp_port_high;
		logic [9:0] url_length;
	} result_t;

	localparam int QDEPTH = 2;
endpackage

### hw/rtl/rhp_front.sv
// Front end: accepts request bytes and parses them into results.
module rhp_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic func,
	input  logic [7:0] data_byte,
	output logic res_valid,
	output rhp_pkg::result_t res
);
	localparam logic [3:0] PH_METHOD = 4'd0;
	localparam logic [3:0] PH_URL = 4'd1;
	localparam logic [3:0] PH_PROTO = 4'd2;
	localparam logic [3:0] PH_HSTART = 4'd3;
	localparam logic [3:0] PH_HNAME = 4'd4;
	localparam logic [3:0] PH_HSPACE = 4'd5;
	localparam logic [3:0] PH_VOTHER = 4'd6;
	localparam logic [3:0] PH_VCSEQ = 4'd7;
	localparam logic [3:0] PH_TPREFIX = 4'd8;
	localparam logic [3:0] PH_PORTA = 4'd9;
	localparam logic [3:0] PH_PORTB = 4'd10;
	localparam logic [1:0] K_OTHER = 2'd0;
	localparam logic [1:0] K_CSEQ = 2'd1;
	localparam logic [1:0] K_TPORT = 2'd2;
	localparam logic [8*28-1:0] TPORT = {"RTP/AVP;unicast;client_", "port="};
	localparam logic [8*8-1:0] PROTO = "RTSP/1.0";

	logic [3:0] phase_q;
	logic [rhp_pkg::LC_W-1:0] lcount_q;
	logic cr_q;
	logic [4:0] idx_q;
	logic [4:0] cand_q;
	logic [2:0] mcode_q;
	logic [1:0] kind_q;
	logic [31:0] acc_q;
	logic [30:0] seq_q;
	logic [15:0] plo_q;
	logic [15:0] phi_q;
	logic [9:0] url_q;

	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [4:0] i);
		logic [8*8-1:0] s;
		logic [3:0] n;
		unique case (k)
			3'd0: begin s = {"OPTIONS", 8'h00}; n = 4'd7; end
			3'd1: begin s = "DESCRIBE"; n = 4'd8; end
			3'd2: begin s = {"SETUP", 24'h0}; n = 4'd5; end
			3'd3: begin s = {"PLAY", 32'h0}; n = 4'd4; end
			3'd4: begin s = "TEARDOWN"; n = 4'd8; end
			3'd5: begin s = {"cseq", 32'h0}; n = 4'd4; end
			3'd6: begin s = '0; n = 4'd9; end
			default: begin s = PROTO; n = 4'd8; end
		endcase
		if (k == 3'd6) begin
			kw_char = (i < 5'd9) ? 8'("transport" >> (8 * (8 - i))) : 8'h00;
		end else if ({1'b0, i} < {2'b0, n}) begin
			kw_char = s[8*(7-i[2:0]) +: 8];
		end else begin
			kw_char = 8'h00;
		end
	endfunction

	function automatic logic [4:0] kw_len(input logic [2:0] k);
		unique case (k)
			3'd0: kw_len = 5'd7;
			3'd1: kw_len = 5'd8;
			3'd2: kw_len = 5'd5;
			3'd3: kw_len = 5'd4;
			3'd4: kw_len = 5'd8;
			3'd5: kw_len = 5'd4;
			3'd6: kw_len = 5'd9;
			default: kw_len = 5'd8;
		endcase
	endfunction

	function automatic logic is_token(input logic [7:0] b);
		if (b < 8'd33 || b > 8'd126) begin
			is_token = 1'b0;
		end else begin
			case (b)
				"(", ")", "<", ">", "@", ",", ";", ":", "\\", 8'h22, "/", "[", "]",
				"?", "=", "{", "}": is_token = 1'b0;
				default: is_token = 1'b1;
			endcase
		end
	endfunction

	logic [3:0] phase_d;
	logic [rhp_pkg::LC_W-1:0] lcount_d;
	logic cr_d;
	logic [4:0] idx_d;
	logic [4:0] cand_d;
	logic [2:0] mcode_d;
	logic [1:0] kind_d;
	logic [31:0] acc_d;
	logic [30:0] seq_d;
	logic [15:0] plo_d;
	logic [15:0] phi_d;
	logic [9:0] url_d;
	logic emit;
	logic clear;
	logic [3:0] st;
	logic is_end;
	logic digit;
	logic [7:0] low;
	logic [35:0] prod;
	logic [4:0] idx_inc;
	logic [4:0] cand_m;
	logic [4:0] cand_h;
	logic [2:0] mfound;
	logic mhit;
	logic [4:0] tidx;

	always_comb begin
		is_end = (data_byte == 8'd13) || (data_byte == 8'd10);
		digit = (data_byte >= "0") && (data_byte <= "9");
		low = (data_byte >= "A" && data_byte <= "Z") ? data_byte + 8'd32 : data_byte;
		prod = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + 36'(data_byte - "0");
		idx_inc = (idx_q < 5'd31) ? idx_q + 5'd1 : idx_q;
		for (int k = 0; k < 5; k++) begin
			cand_m[k] = cand_q[k] && idx_q < kw_len(3'(k)) && kw_char(3'(k), idx_q) == data_byte;
		end
		cand_h = '0;
		for (int k = 0; k < 2; k++) begin
			cand_h[k] = cand_q[k] && idx_q < kw_len(3'(k + 5)) && kw_char(3'(k + 5), idx_q) == low;
		end
		mfound = 3'd0;
		mhit = 1'b0;
		for (int k = 4; k >= 0; k--) begin
			if (cand_q[k] && idx_q == kw_len(3'(k))) begin
				mfound = 3'(k);
				mhit = 1'b1;
			end
		end
		tidx = 5'd27 - idx_q;
	end

	always_comb begin
		phase_d = phase_q; lcount_d = lcount_q; cr_d = cr_q; idx_d = idx_q; cand_d = cand_q;
		mcode_d = mcode_q; kind_d = kind_q; acc_d = acc_q; seq_d = seq_q; plo_d = plo_q;
		phi_d = phi_q; url_d = url_q;
		emit = 1'b0; clear = 1'b0; st = rhp_pkg::ST_OK;
		if (!in_valid) begin
		end else if (func) begin
			clear = 1'b1;
		end else if (cr_q && data_byte == 8'd10) begin
			cr_d = 1'b0;
		end else if (lcount_q >= rhp_pkg::LC_W'(rhp_pkg::LINE_LIMIT)) begin
			emit = 1'b1; clear = 1'b1; st = rhp_pkg::ST_LINE_LONG;
		end else begin
			cr_d = 1'b0;
			lcount_d = lcount_q + 1'b1;
			unique case (phase_q)
				PH_METHOD: begin
					if (data_byte == " ") begin
						if (!mhit) begin
							emit = 1'b1; clear = 1'b1; st = rhp_pkg::ST_BAD_METHOD;
						end else begin
							mcode_d = mfound; phase_d = PH_URL; lcount_d = '0;
						end
					end else if (data_byte >= "A" && data_byte <= "Z") begin
						cand_d = cand_m; idx_d = idx_inc;
					end else begin
						emit = 1'b1; clear = 1'b1; st = rhp_pkg::ST_METHOD_CHAR;
					end
				end
				PH_URL: begin
					if (data_byte == " ") begin
						phase_d = PH_PROTO; lcount_d = '0; idx_d = '0; cand_d = 5'd1;
					end else if (is_end) begin
						emit = 1'b1; clear = 1'b1; st = rhp_pkg::ST_URL_CHAR;
					end else if (url_q != 10'd1023) begin
						url_d = url_q + 10'd1;
					end
				end
				PH_PROTO: begin
					if (is_end) begin
						if (cand_q[0] && idx_q == 5'd8) begin
							phase_d = PH_HSTART; lcount_d = '0; idx_d = '0; cand_d = 5'd3;
							kind_d = K_OTHER; cr_d = (data_byte == 8'd13);
						end else begin
							emit = 1'b1; clear = 1'b1; st = rhp_pkg::ST_PROTO;
						end
					end else begin
						cand_d[0] = cand_q[0] && idx_q < 5'd8 &&
							PROTO[8*(7-idx_q[2:0]) +: 8] == data_byte;
						idx_d = idx_inc;
					end
				end
				PH_HSTART, PH_HNAME: begin
					if (is_end) begin
						if (phase_q != PH_HSTART) begin
							emit = 1'b1; clear = 1'b1; st = rhp_pkg::ST_HDR_CHAR;
						end else begin
							emit = 1'b1; clear = 1'b1; st = rhp_pkg::ST_OK;
							cr_d = (data_byte == 8'd13);
						end
					end else if (data_byte == ":") begin
						kind_d = K_OTHER;
						if (cand_q[0] && idx_q == 5'd4) kind_d = K_CSEQ;
						if (cand_q[1] && idx_q == 5'd9) kind_d = K_TPORT;
						phase_d = PH_HSPACE;
					end else if (is_token(data_byte)) begin
						cand_d = cand_h; idx_d = idx_inc; phase_d = PH_HNAME;
					end else begin
						emit = 1'b1; clear = 1'b1; st = rhp_pkg::ST_HDR_CHAR;
					end
				end
				PH_HSPACE: begin
					if (data_byte != " ") begin
						emit = 1'b1; clear = 1'b1; st = rhp_pkg::ST_NO_SPACE;
					end else begin
						acc_d = '0; idx_d = '0;
						if (kind_q == K_CSEQ) phase_d = PH_VCSEQ;
						else if (kind_q == K_TPORT) phase_d = PH_TPREFIX;
						else phase_d = PH_VOTHER;
					end
				end
				PH_VOTHER: begin
					if (is_end) begin
						phase_d = PH_HSTART; lcount_d = '0; idx_d = '0; cand_d = 5'd3;
						kind_d = K_OTHER; cr_d = (data_byte == 8'd13);
					end
				end
				PH_VCSEQ: begin
					if (is_end) begin
						seq_d = acc_q[30:0];
						phase_d = PH_HSTART; lcount_d = '0; idx_d = '0; cand_d = 5'd3;
						kind_d = K_OTHER; cr_d = (data_byte == 8'd13);
					end else if (digit && prod <= 36'h7FFFFFFF) begin
						acc_d = prod[31:0];
					end else begin
						emit = 1'b1; clear = 1'b1; st = rhp_pkg::ST_CSEQ;
					end
				end
				PH_TPREFIX: begin
					if (idx_q < 5'd28 && data_byte == TPORT[8*tidx +: 8]) begin
						idx_d = idx_q + 5'd1;
						if (idx_q == 5'd27) begin
							phase_d = PH_PORTA; acc_d = '0; idx_d = '0;
						end
					end else begin
						emit = 1'b1; clear = 1'b1; st = rhp_pkg::ST_TRANSPORT;
					end
				end
				PH_PORTA, PH_PORTB: begin
					if (digit) begin
						if (prod > 36'hFFFF) begin
							emit = 1'b1; clear = 1'b1; st = rhp_pkg::ST_PORT;
						end else begin
							acc_d = prod[31:0]; idx_d = 5'd1;
						end
					end else if (phase_q == PH_PORTA && data_byte == "-" && idx_q != '0) begin
						plo_d = acc_q[15:0]; acc_d = '0; idx_d = '0; phase_d = PH_PORTB;
					end else if (phase_q == PH_PORTB && is_end && idx_q != '0) begin
						phi_d = acc_q[15:0];
						phase_d = PH_HSTART; lcount_d = '0; idx_d = '0; cand_d = 5'd3;
						kind_d = K_OTHER; cr_d = (data_byte == 8'd13);
					end else begin
						emit = 1'b1; clear = 1'b1; st = rhp_pkg::ST_PORT;
					end
				end
				default: clear = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_METHOD; lcount_q <= '0; cr_q <= 1'b0; idx_q <= '0; cand_q <= 5'h1f;
			mcode_q <= '0; kind_q <= K_OTHER; acc_q <= '0; seq_q <= '0; plo_q <= '0;
			phi_q <= '0; url_q <= '0; res_valid <= 1'b0;
		end else begin
			res_valid <= emit;
			if (clear) begin
				phase_q <= PH_METHOD; lcount_q <= '0; cr_q <= cr_d && !func && st == rhp_pkg::ST_OK
					&& emit;
				idx_q <= '0; cand_q <= 5'h1f; mcode_q <= '0; kind_q <= K_OTHER; acc_q <= '0;
				seq_q <= '0; plo_q <= '0; phi_q <= '0; url_q <= '0;
			end else begin
				phase_q <= phase_d; lcount_q <= lcount_d; cr_q <= cr_d; idx_q <= idx_d;
				cand_q <= cand_d; mcode_q <= mcode_d; kind_q <= kind_d; acc_q <= acc_d;
				seq_q <= seq_d; plo_q <= plo_d; phi_q <= phi_d; url_q <= url_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res.status <= st;
			if (st == rhp_pkg::ST_OK) begin
				res.method <= mcode_q; res.sequence_number <= seq_q;
				res.rtp_port_low <= plo_q; res.rtp_port_high <= phi_q;
				res.url_length <= url_q;
			end else begin
				res.method <= '0; res.sequence_number <= '0; res.rtp_port_low <= '0;
				res.rtp_port_high <= '0; res.url_length <= '0;
			end
		end
	end
endmodule

### hw/rtl/rhp_queue.sv
// Result queue between the parser and the output side.
`include "rtsp_request_header_parser_top_defines.svh"
module rhp_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  rhp_pkg::result_t wr_data,
	output logic almost_full,
	output logic empty,
	input  logic pop,
	output rhp_pkg::result_t rd_data
);
	localparam int AW = $clog2(rhp_pkg::QDEPTH + 2);
	localparam int DEPTH = rhp_pkg::QDEPTH + 2;
	rhp_pkg::result_t mem_q [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [AW:0] cnt_q;
	logic do_pop;

	assign do_pop = pop && !empty;
	assign empty = (cnt_q == '0);
	assign almost_full = (cnt_q >= (AW + 1)'(rhp_pkg::QDEPTH));
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (do_pop) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW + 1)'(wr_en) - (AW + 1)'(do_pop);
		end
	end

	`RHP_NEVER(a_no_overflow, clk, arst_n, wr_en && cnt_q == (AW + 1)'(DEPTH) && !do_pop, "queue overflow")
	`RHP_ASSERT(a_pop_count, clk, arst_n, do_pop && !wr_en |=> cnt_q == $past(cnt_q) - 1'b1, "count mismatch")
	`RHP_ASSERT(a_push_nonempty, clk, arst_n, wr_en |=> !empty, "push lost")
endmodule

### hw/rtl/rtsp_request_header_parser_top.sv
// A result is registered in the front end, written into the result queue, and reaches the result ports at its head.
// Throughput: one byte per cycle while full is low; the front end parses each byte as it is accepted.
// The front stalls only when the four-entry result queue holds two or more results.
// Reset: arst_n clears the parser to the method phase and empties the queue.
module rtsp_request_header_parser_top (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic func,
	input  logic [7:0] data_byte,
	output logic empty,
	input  logic pop,
	output logic [3:0] status,
	output logic [2:0] method,
	output logic [30:0] sequence_number,
	output logic [15:0] rtp_port_low,
	output logic [15:0] rtp_port_high,
	output logic [9:0] url_length
);
	logic res_valid;
	rhp_pkg::result_t res;
	rhp_pkg::result_t head;

	rhp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(push && !full), .func(func),
		.data_byte(data_byte), .res_valid(res_valid), .res(res)
	);

	rhp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_en(res_valid), .wr_data(res),
		.almost_full(full), .empty(empty), .pop(pop), .rd_data(head)
	);

	assign status = head.status;
	assign method = head.method;
	assign sequence_number = head.sequence_number;
	assign rtp_port_low = head.rtp_port_low;
	assign rtp_port_high = head.rtp_port_high;
	assign url_length = head.url_length;
endmodule

### tb/tb.sv
// Self-checking testbench for the RTSP request header parser, with a byte-level predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		P_METHOD, P_URL, P_PROTO, P_HSTART, P_HNAME, P_HSPACE,
		P_VOTHER, P_VCSEQ, P_VTPFX, P_PORTA, P_PORTB
	} phase_e;

	typedef enum logic [1:0] {K_OTHER, K_CSEQ, K_TRANSPORT} kind_e;

	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic FN_DATA = 1'b0;
	localparam logic FN_ABORT = 1'b1;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int BYTE_TOTAL = 1800;

	class request_scoreboard;
		rhp_pkg::result_t pending[$];
		int errors;
		phase_e ph;
		int lc, cr, idx, cseq_acc, mcode, url_n, seqv, plo, phi;
		logic [4:0] cand;
		kind_e kind;
		string mtext[5];
		string ptxt, htxt[2], tpfx;

		function new();
			mtext = '{"OPTIONS", "DESCRIBE", "SETUP", "PLAY", "TEARDOWN"};
			ptxt = "RTSP/1.0";
			htxt = '{"cseq", "transport"};
			tpfx = {"RTP/AVP;unicast;client_", "port="};
			errors = 0;
			clear_parser();
		endfunction

		function void clear_parser();
			ph = P_METHOD; lc = 0; cr = 0; idx = 0; cand = 5'h1f; mcode = 0;
			kind = K_OTHER; cseq_acc = 0; seqv = 0; plo = 0; phi = 0; url_n = 0;
		endfunction

		function void kw_step(int which, logic [7:0] b);
			string s;
			int n;
			n = (which == 0) ? 5 : ((which == 1) ? 1 : 2);
			for (int k = 0; k < n; k++) begin
				s = (which == 0) ? mtext[k] : ((which == 1) ? ptxt : htxt[k]);
				if (cand[k] && (idx >= s.len() || s[idx] != b)) cand[k] = 1'b0;
			end
			if (idx < 31) idx++;
		endfunction

		function bit token_char(logic [7:0] b);
			if (b < 33 || b > 126) return 0;
			case (b)
				"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?",
				"=", "{", "}": return 0;
				default: return 1;
			endcase
		endfunction

		function void fail(logic [3:0] st);
			rhp_pkg::result_t r;
			r = '0;
			r.status = st;
			pending.push_back(r);
			clear_parser();
		endfunction

		function void line_done(logic [7:0] b);
			ph = P_HSTART; lc = 0; idx = 0; cand = 5'h3; kind = K_OTHER;
			cr = (b == CH_CR);
		endfunction

		function void note_request(logic fn, logic [7:0] b);
			bit eol, dig;
			longint t;
			int k;
			rhp_pkg::result_t r;
			eol = (b == CH_CR || b == CH_LF);
			dig = (b >= "0" && b <= "9");
			if (fn == FN_ABORT) begin
				clear_parser();
				return;
			end
			if (cr) begin
				cr = 0;
				if (b == CH_LF) return;
			end
			if (lc >= rhp_pkg::LINE_LIMIT) begin
				fail(rhp_pkg::ST_LINE_LONG);
				return;
			end
			lc++;
			case (ph)
				P_METHOD: begin
					if (b == " ") begin
						for (k = 0; k < 5; k++)
							if (cand[k] && idx == mtext[k].len()) break;
						if (k == 5) begin
							fail(rhp_pkg::ST_BAD_METHOD);
							return;
						end
						mcode = k; ph = P_URL; lc = 0;
					end else if (b >= "A" && b <= "Z") kw_step(0, b);
					else fail(rhp_pkg::ST_METHOD_CHAR);
				end
				P_URL: begin
					if (b == " ") begin
						ph = P_PROTO; lc = 0; idx = 0; cand = 5'h1;
					end else if (eol) fail(rhp_pkg::ST_URL_CHAR);
					else if (url_n < 1023) url_n++;
				end
				P_PROTO: begin
					if (eol) begin
						if (cand[0] && idx == 8) line_done(b);
						else fail(rhp_pkg::ST_PROTO);
					end else kw_step(1, b);
				end
				P_HSTART, P_HNAME: begin
					if (eol) begin
						if (ph != P_HSTART) begin
							fail(rhp_pkg::ST_HDR_CHAR);
							return;
						end
						r.status = rhp_pkg::ST_OK;
						r.method = 3'(mcode);
						r.sequence_number = 31'(seqv);
						r.rtp_port_low = 16'(plo);
						r.rtp_port_high = 16'(phi);
						r.url_length = 10'(url_n);
						pending.push_back(r);
						clear_parser();
						cr = (b == CH_CR);
					end else if (b == ":") begin
						kind = K_OTHER;
						if (cand[0] && idx == 4) kind = K_CSEQ;
						if (cand[1] && idx == 9) kind = K_TRANSPORT;
						ph = P_HSPACE;
					end else if (token_char(b)) begin
						kw_step(2, (b >= "A" && b <= "Z") ? b + 8'd32 : b);
						ph = P_HNAME;
					end else fail(rhp_pkg::ST_HDR_CHAR);
				end
				P_HSPACE: begin
					if (b != " ") begin
						fail(rhp_pkg::ST_NO_SPACE);
						return;
					end
					cseq_acc = 0; idx = 0;
					ph = (kind == K_CSEQ) ? P_VCSEQ : ((kind == K_TRANSPORT) ? P_VTPFX : P_VOTHER);
				end
				P_VOTHER: if (eol) line_done(b);
				P_VCSEQ: begin
					if (eol) begin
						seqv = cseq_acc;
						line_done(b);
					end else if (dig) begin
						t = longint'(cseq_acc) * 10 + (b - "0");
						if (t > 64'h7fffffff) fail(rhp_pkg::ST_CSEQ);
						else cseq_acc = int'(t);
					end else fail(rhp_pkg::ST_CSEQ);
				end
				P_VTPFX: begin
					if (idx < 28 && b == tpfx[idx]) begin
						idx++;
						if (idx == 28) begin
							ph = P_PORTA; cseq_acc = 0; idx = 0;
						end
					end else fail(rhp_pkg::ST_TRANSPORT);
				end
				P_PORTA, P_PORTB: begin
					if (dig) begin
						t = longint'(cseq_acc) * 10 + (b - "0");
						if (t > 65535) fail(rhp_pkg::ST_PORT);
						else begin
							cseq_acc = int'(t); idx = 1;
						end
					end else if (ph == P_PORTA && b == "-" && idx != 0) begin
						plo = cseq_acc; cseq_acc = 0; idx = 0; ph = P_PORTB;
					end else if (ph == P_PORTB && eol && idx != 0) begin
						phi = cseq_acc;
						line_done(b);
					end else fail(rhp_pkg::ST_PORT);
				end
				default: clear_parser();
			endcase
		endfunction

		function void check_result(rhp_pkg::result_t got);
			rhp_pkg::result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result status=%0d", got.status);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status) begin
				$error("status expected %0d actual %0d", e.status, got.status); errors++;
			end
			if (got.method !== e.method) begin
				$error("method expected %0d actual %0d", e.method, got.method); errors++;
			end
			if (got.sequence_number !== e.sequence_number) begin
				$error("sequence_number expected %0d actual %0d", e.sequence_number,
					got.sequence_number);
				errors++;
			end
			if (got.rtp_port_low !== e.rtp_port_low) begin
				$error("rtp_port_low expected %0d actual %0d", e.rtp_port_low,
					got.rtp_port_low);
				errors++;
			end
			if (got.rtp_port_high !== e.rtp_port_high) begin
				$error("rtp_port_high expected %0d actual %0d", e.rtp_port_high,
					got.rtp_port_high);
				errors++;
			end
			if (got.url_length !== e.url_length) begin
				$error("url_length expected %0d actual %0d", e.url_length, got.url_length);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0, push = 0, func = 0, pop = 0;
	logic [7:0] data_byte = 0;
	logic full, empty;
	logic [3:0] status;
	logic [2:0] method;
	logic [30:0] sequence_number;
	logic [15:0] rtp_port_low, rtp_port_high;
	logic [9:0] url_length;
	request_scoreboard sb;
	int cycles = 0;
	bit rx_on = 0;

	rtsp_request_header_parser_top u_top (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver stalls on a rotating pattern with quiet stretches.
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_result('{status, method, sequence_number, rtp_port_low,
				rtp_port_high, url_length});
		if (!rx_on) pop <= 1'b0;
		else if ((cycles / 500) % 3 == 0) pop <= 1'b1;
		else pop <= ((cycles % 7) < 4) || ($urandom_range(0, 3) == 0);
	end

	int burst = 0;
	int n_sent = 0;

	task automatic send_byte(input logic fn, input logic [7:0] b);
		int gap;
		if (burst == 0) begin
			gap = $urandom_range(0, 4);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst = $urandom_range(1, 40);
		end
		burst--;
		push <= 1'b1;
		func <= fn;
		data_byte <= b;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_request(fn, b);
		n_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(FN_DATA, s[i]);
	endtask

	function automatic string rand_digits(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
		return s;
	endfunction

	function automatic string rand_request();
		string s, m[5], eol;
		m = '{"OPTIONS", "DESCRIBE", "SETUP", "PLAY", "TEARDOWN"};
		eol = ($urandom_range(0, 2) == 0) ? "\n" : (($urandom_range(0, 1)) ? "\r" : "\r\n");
		s = {m[$urandom_range(0, 4)], " rtsp://h/", rand_digits($urandom_range(0, 5)),
			" RTSP/1.0", eol};
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(0, 2))
				0: s = {s, ($urandom_range(0, 1) ? "CSeq: " : "cSEQ: "),
					rand_digits($urandom_range(0, 10)), eol};
				1: s = {s, "Transport: RTP/AVP;unicast;client_", "port=",
					rand_digits($urandom_range(1, 5)), "-", rand_digits($urandom_range(1, 5)), eol};
				default: s = {s, "X-Hdr: ", rand_digits(3), eol};
			endcase
		end
		return {s, eol};
	endfunction

	task automatic send_mutated(input string s);
		int pos;
		pos = $urandom_range(0, s.len() - 1);
		for (int i = 0; i < s.len(); i++) begin
			if (i == pos) send_byte(FN_DATA, 8'($urandom()));
			else send_byte(FN_DATA, s[i]);
		end
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		rx_on = 1;
		send_text("OPTIONS * RTSP/1.0\r\nCSeq: 2147483647\r\n\r\n");
		send_text({"TEARDOWN u RTSP/1.0\nTransport: RTP/AVP;unicast;client_",
			"port=65535-0\n\n"});
		send_text("PLAYX ");
		send_text("play");
		send_text("SETUP a\r");
		send_text("SETUP a RTSP/1.1\r");
		send_text("DESCRIBE a RTSP/1.0\r\nB@d");
		send_text("DESCRIBE a RTSP/1.0\r\nX:y");
		send_text("DESCRIBE a RTSP/1.0\r\nCSeq: 2147483648\r");
		send_text("DESCRIBE a RTSP/1.0\r\nCSeq: -1\r");
		send_text("PLAY a RTSP/1.0\r\nTransport: RTP/AVP;multicast\r");
		send_text({"PLAY a RTSP/1.0\r\nTransport: RTP/AVP;unicast;client_",
			"port=65536-1\r"});
		send_text({"PLAY a RTSP/1.0\r\nTransport: RTP/AVP;unicast;client_",
			"port=-1\r"});
		send_text("PLAY a RTSP/1.0\r\n: x\r\nNm\r");
		send_text("OPT");
		send_byte(FN_ABORT, 8'hff);
		send_text("PLAY ");
		for (int i = 0; i < 1030; i++) send_byte(FN_DATA, "u");
		send_text("PLAY a RTSP/1.0\r\n\r\n");
		while (n_sent < BYTE_TOTAL) begin
			string s;
			s = rand_request();
			case ($urandom_range(0, 9))
				0: send_mutated(s);
				1: send_byte(FN_ABORT, 8'($urandom()));
				2: send_byte(FN_DATA, 8'($urandom()));
				default: send_text(s);
			endcase
		end
		push <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule
